// ----- design/tpgoc_pkg.sv -----
// Shared types and constants of the two-point gain and offset calibrator.
package tpgoc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int RATIO_W = 16;
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] OFFSET_SCALE = 10'd1000;

    localparam logic [CFG_ADDR_W-1:0] CFG_VOLTAGE_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_P1_RATIO = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_P2_RATIO = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DELTA = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_MIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_MAX = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_MIN = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_MAX = 3'd7;

    typedef logic [2:0] status_t;
    localparam status_t ST_STORED = 3'd0;
    localparam status_t ST_COMPUTED = 3'd1;
    localparam status_t ST_P1_MISMATCH = 3'd2;
    localparam status_t ST_TOO_CLOSE = 3'd3;
    localparam status_t ST_P2_MISMATCH = 3'd4;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;

    typedef enum logic [2:0] {
        OP_SENSE, OP_OUT, OP_DIV1, OP_MUL1, OP_DIV2, OP_MUL2, OP_MUL3
    } op_t;

    typedef enum logic [1:0] {SH_RATIO, SH_FRAC, SH_NONE} shift_t;

    typedef struct packed {
        logic   start;
        logic   is_div;
        shift_t shift;
    } alu_req_t;

endpackage

// ----- design/tpgoc_if.sv -----
// Handshake interfaces for calibration points and calibration results.
interface tpgoc_point_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measured_value;
    logic signed [DATA_WIDTH-1:0] true_value;
    logic signed [DATA_WIDTH-1:0] set_current;

    modport source (output valid, measured_value, true_value, set_current, input ready);
    modport sink (input valid, measured_value, true_value, set_current, output ready);
endinterface

interface tpgoc_result_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic                         sense_mismatch;
    logic                         output_mismatch;
    logic signed [DATA_WIDTH-1:0] sensor_gain;
    logic signed [DATA_WIDTH-1:0] sensor_offset;
    logic signed [DATA_WIDTH-1:0] output_gain;
    logic signed [DATA_WIDTH-1:0] output_offset;

    modport source (output valid, status, sense_mismatch, output_mismatch, sensor_gain,
                    sensor_offset, output_gain, output_offset, input ready);
    modport sink (input valid, status, sense_mismatch, output_mismatch, sensor_gain,
                  sensor_offset, output_gain, output_offset, output ready);
endinterface

// ----- design/tpgoc_alu.sv -----
// Shared bit-serial unsigned multiplier and restoring divider.
module tpgoc_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpgoc_pkg::alu_req_t   req,
    input  logic [DATA_WIDTH:0]   opa,
    input  logic [DATA_WIDTH:0]   opb,
    output logic                  done,
    output logic [DATA_WIDTH:0]   mag
);
    import tpgoc_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int DIV_STEPS = W + 1 + FRAC_BITS;
    localparam int MUL_STEPS = W + 1;
    localparam int CW = $clog2(DIV_STEPS + 1);

    logic            busy_reg;
    logic            done_reg;
    logic            is_div_reg;
    shift_t          shift_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W:0]      opa_reg;
    logic [W:0]      mb_reg;
    logic [W:0]      acc_reg;
    logic [W+FRAC_BITS:0] dvd_reg;
    logic [W+1:0]    q_reg;
    logic            ovf_reg;

    logic [W+1:0]    mul_sum;
    logic [W+1:0]    trial;
    logic            fits;
    logic [W+1:0]    trial_diff;
    logic            last;
    logic [2*W+1:0]  prod;
    logic [2*W+1:0]  shifted;
    logic [W:0]      psat;
    logic [W:0]      qsat;

    assign mul_sum = {1'b0, acc_reg} + (mb_reg[0] ? {1'b0, opa_reg} : '0);
    assign trial = {acc_reg, dvd_reg[W+FRAC_BITS]};
    assign fits = trial >= {1'b0, opa_reg};
    assign trial_diff = trial - {1'b0, opa_reg};
    assign last = is_div_reg ? (cnt_reg == CW'(DIV_STEPS - 1)) : (cnt_reg == CW'(MUL_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            is_div_reg <= req.is_div;
            shift_reg <= req.shift;
            opa_reg <= req.is_div ? opb : opa;
            mb_reg <= opb;
            dvd_reg <= {opa, {FRAC_BITS{1'b0}}};
            acc_reg <= '0;
            q_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                dvd_reg <= {dvd_reg[W+FRAC_BITS-1:0], 1'b0};
                acc_reg <= fits ? trial_diff[W:0] : trial[W:0];
                q_reg <= {q_reg[W:0], fits};
                ovf_reg <= ovf_reg | q_reg[W+1];
            end
            else
            begin
                acc_reg <= mul_sum[W+1:1];
                mb_reg <= {mul_sum[0], mb_reg[W:1]};
            end
        end
    end

    assign prod = {acc_reg, mb_reg};

    always_comb
    begin
        case (shift_reg)
            SH_RATIO: shifted = prod >> RATIO_W;
            SH_FRAC:  shifted = prod >> FRAC_BITS;
            default:  shifted = prod;
        endcase
    end

    assign psat = (|shifted[2*W+1:W]) ? {1'b1, {W{1'b0}}} : {1'b0, shifted[W-1:0]};
    assign qsat = (ovf_reg | q_reg[W+1] | q_reg[W]) ? {1'b1, {W{1'b0}}} : q_reg[W:0];
    assign mag = is_div_reg ? qsat : psat;
    assign done = done_reg;

endmodule

// ----- design/two_point_gain_offset_calibrator.sv -----
// Two-point gain and offset calibrator, top level.
//
//  Channel   Direction  Handshake     Carries
//  point     in         valid/ready   measured_value, true_value, set_current
//  result    out        valid/ready   status, mismatch flags, gains, offsets
//  cfg       in         cfg_we        cfg_addr, cfg_wdata
//
// One point is worked on at a time; every multiply and divide runs on one shared
// bit-serial unit. A point rejected for spacing skips the arithmetic unit, a point
// check runs up to two multiplies, and a computed current-mode point runs two
// divides and five multiplies.
// Reset restores the register defaults and ends any session. A stalled result
// stays in the output register; the block finishes the next point behind it and
// holds that result until the output register is free.
module two_point_gain_offset_calibrator #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tpgoc_point_if.sink                       point,
    tpgoc_result_if.source                    result,
    input  logic                              cfg_we,
    input  logic [tpgoc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [DATA_WIDTH-1:0]             cfg_wdata
);
    import tpgoc_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int W1 = W + 1;
    localparam int XW = W + 2;
    localparam int EPS_Q = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [W:0] EPS_MAG = W1'(EPS_Q);
    localparam logic signed [W-1:0] ONE_Q = {{(W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [W-1:0] LIM_LO = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] LIM_HI = {1'b0, {(W-1){1'b1}}};

    function automatic logic [W:0] mag_of(input logic signed [W:0] v);
        return v[W] ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] clamp_to(input logic signed [XW-1:0] v,
                                                     input logic signed [W-1:0] lo,
                                                     input logic signed [W-1:0] hi);
        logic signed [XW-1:0] r;
        r = v;
        if (r > XW'(hi))
        begin
            r = XW'(hi);
        end
        if (r < XW'(lo))
        begin
            r = XW'(lo);
        end
        return W'(r);
    endfunction

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic                  vmode_reg;
    logic [RATIO_W-1:0]    p1_ratio_reg;
    logic [RATIO_W-1:0]    p2_ratio_reg;
    logic [W-2:0]          min_delta_reg;
    logic signed [W-1:0]   gain_min_reg, gain_max_reg, offset_min_reg, offset_max_reg;

    logic                  first_taken_reg;
    logic                  second_reg;
    logic signed [W-1:0]   m_reg, t_reg, s_reg;
    logic signed [W-1:0]   fm_reg, ft_reg, fs_reg;

    status_t               status_reg;
    logic                  smis_reg, omis_reg;
    logic signed [W-1:0]   sg_reg, so_reg, og_reg, oo_reg;

    logic                  rvalid_reg;
    status_t               r_status_reg;
    logic                  r_smis_reg, r_omis_reg;
    logic signed [W-1:0]   r_sg_reg, r_so_reg, r_og_reg, r_oo_reg;

    logic                  point_acc;
    logic signed [W:0]     spread;
    logic                  too_close;
    logic signed [W:0]     d_mt, d_st, d_num, d_dm, d_ds;
    logic [W:0]            abs_m, abs_s;
    logic [W:0]            alu_opa, alu_opb;
    alu_req_t              alu_req;
    logic                  alu_done;
    logic [W:0]            alu_mag;
    logic                  neg;
    logic signed [XW-1:0]  alu_s;
    logic signed [W:0]     den;
    logic signed [XW-1:0]  gain_raw;
    logic signed [W-1:0]   gain_c, off_c, scale_c;
    logic                  exceed;
    logic                  judge_now;
    logic                  judge_mis;
    logic                  out_free;

    assign point_acc = point.valid && point.ready;
    assign point.ready = (state_reg == S_IDLE);
    assign out_free = !rvalid_reg || result.ready;

    assign spread = vmode_reg ? (W1'(point.measured_value) - W1'(fm_reg))
                              : (W1'(point.set_current) - W1'(fs_reg));
    assign too_close = mag_of(spread) < {2'b00, min_delta_reg};

    assign d_mt = W1'(m_reg) - W1'(t_reg);
    assign d_st = W1'(s_reg) - W1'(t_reg);
    assign d_num = W1'(t_reg) - W1'(ft_reg);
    assign d_dm = W1'(m_reg) - W1'(fm_reg);
    assign d_ds = W1'(s_reg) - W1'(fs_reg);
    assign abs_m = mag_of(W1'(m_reg));
    assign abs_s = mag_of(W1'(s_reg));

    always_comb
    begin
        alu_opa = '0;
        alu_opb = '0;
        alu_req.start = (state_reg == S_ISSUE);
        alu_req.is_div = 1'b0;
        alu_req.shift = SH_FRAC;
        neg = 1'b0;
        unique case (op_reg)
            OP_SENSE, OP_OUT:
            begin
                alu_opa = (op_reg == OP_SENSE) ? ((abs_m < EPS_MAG) ? EPS_MAG : abs_m)
                                               : ((abs_s < EPS_MAG) ? EPS_MAG : abs_s);
                alu_opb = W1'(second_reg ? p2_ratio_reg : p1_ratio_reg);
                alu_req.shift = SH_RATIO;
            end
            OP_DIV1:
            begin
                alu_opa = mag_of(d_num);
                alu_opb = mag_of(d_dm);
                alu_req.is_div = 1'b1;
                neg = d_num[W] ^ d_dm[W];
            end
            OP_MUL1:
            begin
                alu_opa = mag_of(W1'(fm_reg));
                alu_opb = mag_of(W1'(sg_reg));
                neg = fm_reg[W-1] ^ sg_reg[W-1];
            end
            OP_DIV2:
            begin
                alu_opa = mag_of(d_num);
                alu_opb = mag_of(d_ds);
                alu_req.is_div = 1'b1;
                neg = d_num[W] ^ d_ds[W];
            end
            OP_MUL2:
            begin
                alu_opa = mag_of(W1'(fs_reg));
                alu_opb = mag_of(W1'(og_reg));
                neg = fs_reg[W-1] ^ og_reg[W-1];
            end
            OP_MUL3:
            begin
                alu_opa = mag_of(W1'(oo_reg));
                alu_opb = W1'(OFFSET_SCALE);
                alu_req.shift = SH_NONE;
                neg = oo_reg[W-1];
            end
            default:
            begin
                alu_opa = '0;
            end
        endcase
    end

    tpgoc_alu #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .opa   (alu_opa),
        .opb   (alu_opb),
        .done  (alu_done),
        .mag   (alu_mag)
    );

    assign alu_s = neg ? -$signed({1'b0, alu_mag}) : $signed({1'b0, alu_mag});
    assign den = (op_reg == OP_DIV1) ? d_dm : d_ds;

    always_comb
    begin
        if (den == '0)
        begin
            if (!d_num[W] && (|d_num))
            begin
                gain_raw = XW'(gain_max_reg);
            end
            else if (d_num[W])
            begin
                gain_raw = XW'(gain_min_reg);
            end
            else
            begin
                gain_raw = '0;
            end
        end
        else
        begin
            gain_raw = alu_s;
        end
    end

    assign gain_c = clamp_to(gain_raw, gain_min_reg, gain_max_reg);
    assign off_c = clamp_to(XW'(ft_reg) - alu_s, offset_min_reg, offset_max_reg);
    assign scale_c = clamp_to(alu_s, LIM_LO, LIM_HI);
    assign exceed = ((op_reg == OP_SENSE) ? mag_of(d_mt) : mag_of(d_st)) > alu_mag;
    assign judge_now = (state_reg == S_WAIT) && alu_done
                       && (((op_reg == OP_SENSE) && vmode_reg) || (op_reg == OP_OUT));
    assign judge_mis = exceed || smis_reg;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (point_acc)
                begin
                    if (first_taken_reg && too_close)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                        op_next = OP_SENSE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = S_ISSUE;
                    unique case (op_reg)
                        OP_SENSE, OP_OUT:
                        begin
                            if ((op_reg == OP_SENSE) && !vmode_reg)
                            begin
                                op_next = OP_OUT;
                            end
                            else if (!second_reg || judge_mis)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                op_next = OP_DIV1;
                            end
                        end
                        OP_DIV1: op_next = OP_MUL1;
                        OP_MUL1:
                        begin
                            if (vmode_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                op_next = OP_DIV2;
                            end
                        end
                        OP_DIV2: op_next = OP_MUL2;
                        OP_MUL2: op_next = OP_MUL3;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_SENSE;
            rvalid_reg <= 1'b0;
            first_taken_reg <= 1'b0;
            vmode_reg <= 1'b0;
            p1_ratio_reg <= RATIO_W'(6554);
            p2_ratio_reg <= RATIO_W'(6554);
            min_delta_reg <= (W-1)'(65536);
            gain_min_reg <= W'(52429);
            gain_max_reg <= W'(78643);
            offset_min_reg <= W'(-65536);
            offset_max_reg <= W'(65536);
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                rvalid_reg <= 1'b0;
            end
            if (point_acc && first_taken_reg)
            begin
                first_taken_reg <= 1'b0;
            end
            else if (judge_now && !second_reg && !judge_mis)
            begin
                first_taken_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_VOLTAGE_MODE:
                    begin
                        vmode_reg <= cfg_wdata[0];
                        first_taken_reg <= 1'b0;
                    end
                    CFG_P1_RATIO:   p1_ratio_reg <= cfg_wdata[RATIO_W-1:0];
                    CFG_P2_RATIO:   p2_ratio_reg <= cfg_wdata[RATIO_W-1:0];
                    CFG_MIN_DELTA:  min_delta_reg <= cfg_wdata[W-2:0];
                    CFG_GAIN_MIN:   gain_min_reg <= cfg_wdata;
                    CFG_GAIN_MAX:   gain_max_reg <= cfg_wdata;
                    CFG_OFFSET_MIN: offset_min_reg <= cfg_wdata;
                    CFG_OFFSET_MAX: offset_max_reg <= cfg_wdata;
                    default:        vmode_reg <= vmode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_acc)
        begin
            m_reg <= point.measured_value;
            t_reg <= point.true_value;
            s_reg <= point.set_current;
            second_reg <= first_taken_reg;
            status_reg <= first_taken_reg ? ST_TOO_CLOSE : ST_STORED;
            smis_reg <= 1'b0;
            omis_reg <= 1'b0;
            sg_reg <= ONE_Q;
            so_reg <= '0;
            og_reg <= ONE_Q;
            oo_reg <= '0;
        end
        if ((state_reg == S_WAIT) && alu_done)
        begin
            case (op_reg)
                OP_SENSE: smis_reg <= exceed;
                OP_OUT:   omis_reg <= exceed;
                OP_DIV1:  sg_reg <= gain_c;
                OP_MUL1:  so_reg <= off_c;
                OP_DIV2:  og_reg <= gain_c;
                OP_MUL2:  oo_reg <= off_c;
                default:  oo_reg <= scale_c;
            endcase
        end
        if (judge_now)
        begin
            if (!second_reg)
            begin
                if (judge_mis)
                begin
                    status_reg <= ST_P1_MISMATCH;
                end
                else
                begin
                    status_reg <= ST_STORED;
                    fm_reg <= m_reg;
                    ft_reg <= t_reg;
                    fs_reg <= s_reg;
                end
            end
            else
            begin
                status_reg <= judge_mis ? ST_P2_MISMATCH : ST_COMPUTED;
            end
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            r_status_reg <= status_reg;
            r_smis_reg <= smis_reg;
            r_omis_reg <= omis_reg;
            r_sg_reg <= sg_reg;
            r_so_reg <= so_reg;
            r_og_reg <= og_reg;
            r_oo_reg <= oo_reg;
        end
    end

    assign result.valid = rvalid_reg;
    assign result.status = r_status_reg;
    assign result.sense_mismatch = r_smis_reg;
    assign result.output_mismatch = r_omis_reg;
    assign result.sensor_gain = r_sg_reg;
    assign result.sensor_offset = r_so_reg;
    assign result.output_gain = r_og_reg;
    assign result.output_offset = r_oo_reg;

    a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> (state_reg == S_WAIT))
        else $error("arithmetic unit finished outside a wait state");

    a_result_follows_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised without a finished transaction");

    a_computed_has_no_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && (r_status_reg == ST_COMPUTED) |-> !r_smis_reg && !r_omis_reg)
        else $error("computed result carries a mismatch flag");

    a_voltage_no_output_check: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && vmode_reg |-> !r_omis_reg)
        else $error("output mismatch reported in voltage mode");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !point_acc)
        else $error("point taken while the previous one is in progress");

endmodule
